// ===== rtl/core/rcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg: shared types and constants for the RGB channel split filter
// Channel widths, shift register reset value and sequencer state codes.
// ----------------------------------------------------------------------------
package rcs_pkg;

  // one color channel, 255 stands for 1.0
  localparam int CH_W = 8;
  // shift distance register
  localparam int SHIFT_W = 6;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd30;
  // packed pixel on the stream: red, green, blue from the low bit up
  localparam int PIX_W = 3 * CH_W;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_ISSUE   = 3'b010,
    ST_CAPTURE = 3'b100
  } seq_state_t;

endpackage

// ===== rtl/core/rcs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rcs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_ctrl: column tracking and read sequencer for the RGB channel split
// Writes each pixel into the ring, then walks the columns due for output,
// addressing the red and green rings and handing the results to the output
// register one at a time.
// ----------------------------------------------------------------------------
module rcs_ctrl #(
  parameter int RING_DEPTH = 128,
  parameter int MAX_LINE   = 4096,
  localparam int AW = $clog2(RING_DEPTH),
  localparam int CW = $clog2(MAX_LINE)
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [rcs_pkg::SHIFT_W-1:0] cfg_wr_data,
  // input item
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_last,
  input  logic [rcs_pkg::CH_W-1:0]    in_blue,
  // ring memories
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [AW-1:0]               red_raddr,
  output logic [AW-1:0]               green_raddr,
  // output register handoff
  input  logic                        out_free,
  output logic                        out_load,
  output logic                        out_last,
  output logic [rcs_pkg::CH_W-1:0]    out_blue
);

  import rcs_pkg::*;

  seq_state_t         state, state_next;
  logic [SHIFT_W-1:0] shift_reg;
  logic [SHIFT_W-1:0] line_shift;
  logic [CW-1:0]      col_count;
  logic [AW-1:0]      ring_ptr;
  logic [CW-1:0]      cur_col;
  logic [AW-1:0]      cur_idx;
  logic [CW-1:0]      last_col;
  logic               flush;
  logic [CH_W-1:0]    blue;

  logic               accept;
  logic [SHIFT_W-1:0] d_now;
  logic               c_ge_d;
  logic               end_now;
  logic [AW-1:0]      back_idx;
  logic               at_last;

  // ring index a minus d, modulo the ring depth (d is below the depth)
  function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a,
                                             input logic [SHIFT_W-1:0] dd);
    logic [AW:0] sum;
    if (a >= AW'(dd)) begin
      sum = {1'b0, a} - (AW+1)'(dd);
    end else begin
      sum = {1'b0, a} + (AW+1)'(RING_DEPTH) - (AW+1)'(dd);
    end
    return sum[AW-1:0];
  endfunction

  // no item is taken while reset is held
  assign in_ready = (state == ST_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  // shift is latched at the first pixel of a line
  assign d_now    = (col_count == '0) ? shift_reg : line_shift;
  assign c_ge_d   = (col_count >= CW'(d_now));
  assign end_now  = in_last || (col_count == CW'(MAX_LINE - 1));
  assign back_idx = wrap_sub(ring_ptr, d_now);

  // ring write on accept
  assign ram_we    = accept;
  assign ram_waddr = ring_ptr;

  // read addresses of the column being output
  assign green_raddr = cur_idx;
  assign red_raddr   = (cur_col >= CW'(line_shift)) ? wrap_sub(cur_idx, line_shift) : '0;

  // blue always clamps to the newest pixel of the line
  assign at_last  = (cur_col == last_col);
  assign out_last = flush && at_last;
  assign out_blue = blue;
  assign out_load = (state == ST_CAPTURE) && out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg <= SHIFT_RESET;
    end else if (cfg_wr_en) begin
      shift_reg <= cfg_wr_data;
    end
  end

  // column and ring position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      ring_ptr   <= '0;
      line_shift <= SHIFT_RESET;
    end else if (accept) begin
      line_shift <= d_now;
      if (end_now) begin
        col_count <= '0;
        ring_ptr  <= '0;
      end else begin
        col_count <= col_count + 1'b1;
        ring_ptr  <= (ring_ptr == AW'(RING_DEPTH - 1)) ? '0 : ring_ptr + 1'b1;
      end
    end
  end

  // output column walk
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_col  <= c_ge_d ? (col_count - CW'(d_now)) : '0;
      cur_idx  <= c_ge_d ? back_idx : '0;
      last_col <= col_count;
      flush    <= end_now;
      blue     <= in_blue;
    end else if (out_load && flush && !at_last) begin
      cur_col <= cur_col + 1'b1;
      cur_idx <= (cur_idx == AW'(RING_DEPTH - 1)) ? '0 : cur_idx + 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (end_now || c_ge_d)) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_next = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        if (out_free) begin
          state_next = (flush && !at_last) ? ST_ISSUE : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/rgb_channel_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_channel_split: streaming chromatic offset filter
// Output pixel j takes red from column j-D, green from j, blue from j+D,
// clamped to the line edges. Red and green sit in two ring memories.
// ----------------------------------------------------------------------------
// Output runs D columns (shift_distance, latched at the first pixel of each
// line) behind input. Every pixel is written to the rings in the cycle it is
// accepted. A pixel that produces output goes through accept, ring read
// (registered memory) and capture into the output register; capture waits
// while the output register is full. On a line end (tlast, or column
// MAX_LINE-1) the remaining min(c,D)+1 columns are flushed after the accept,
// each by a ring read and a capture, with the input held off meanwhile. The
// output register lets the next input item in while the last result waits.
// Ring contents need no clearing after reset: only columns already written in
// the current line are read.
// ----------------------------------------------------------------------------
module rgb_channel_split #(
  parameter int RING_DEPTH = 128,
  parameter int MAX_LINE   = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [rcs_pkg::SHIFT_W-1:0] cfg_wr_data,    // shift_distance
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rcs_pkg::PIX_W-1:0]   s_axis_tdata,   // red_in, green_in, blue_in
  input  logic                        s_axis_tlast,   // line_end_in
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [rcs_pkg::PIX_W-1:0]   m_axis_tdata,   // red_out, green_out, blue_out
  output logic                        m_axis_tlast    // line_end_out
);

  import rcs_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   red_raddr;
  logic [AW-1:0]   green_raddr;
  logic [CH_W-1:0] red_rdata;
  logic [CH_W-1:0] green_rdata;
  logic            out_free;
  logic            out_load;
  logic            out_last;
  logic [CH_W-1:0] out_blue;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // sequencer
  rcs_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_LINE   (MAX_LINE)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_last     (s_axis_tlast),
    .in_blue     (s_axis_tdata[3*CH_W-1:2*CH_W]),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .red_raddr   (red_raddr),
    .green_raddr (green_raddr),
    .out_free    (out_free),
    .out_load    (out_load),
    .out_last    (out_last),
    .out_blue    (out_blue)
  );

  // red ring
  rcs_ram #(
    .WIDTH (CH_W),
    .DEPTH (RING_DEPTH)
  ) u_red_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_axis_tdata[CH_W-1:0]),
    .raddr (red_raddr),
    .rdata (red_rdata)
  );

  // green ring
  rcs_ram #(
    .WIDTH (CH_W),
    .DEPTH (RING_DEPTH)
  ) u_green_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_axis_tdata[2*CH_W-1:CH_W]),
    .raddr (green_raddr),
    .rdata (green_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {out_blue, green_rdata, red_rdata};
      m_axis_tlast <= out_last;
    end
  end

endmodule
